@@ design/occs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occs_pkg - shared types, constants and elaboration-time tables
// Formats, octant codes, item tag and the CORDIC arctangent / gain tables
// for the octant cosine/sine unit.
// ----------------------------------------------------------------------------
package occs_pkg;

  // Port widths, fixed by the interface
  localparam int PHASE_W = 32;
  localparam int OUT_W   = 18;

  // Defaults handed to the top level
  localparam int PHASE_FRAC_BITS_DEF = 24;
  localparam int OUT_FRAC_BITS_DEF   = 16;
  localparam int CORDIC_STAGES_DEF   = 18;

  // CORDIC datapath: signed Q.40 with headroom
  localparam int WORK_FRAC = 40;
  localparam int WORK_W    = 44;

  // 2*pi in Q.32, split for two narrow partial products
  localparam int TWO_PI_W    = 35;
  localparam int TWO_PI_LO_W = 18;
  localparam int TWO_PI_HI_W = TWO_PI_W - TWO_PI_LO_W;
  localparam logic [TWO_PI_W-1:0]    TWO_PI_Q32 = 35'h6487ED511;
  localparam logic [TWO_PI_LO_W-1:0] TWO_PI_LO  = TWO_PI_Q32[TWO_PI_LO_W-1:0];
  localparam logic [TWO_PI_HI_W-1:0] TWO_PI_HI  = TWO_PI_Q32[TWO_PI_W-1:TWO_PI_LO_W];

  // pi in Q.60 (pi/4 in Q.62)
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // Register counts outside the two cell chains
  localparam int FRONT_REGS = 6;
  localparam int BACK_REGS  = 6;

  typedef enum logic [2:0] {
    OCT_0 = 3'd0,
    OCT_1 = 3'd1,
    OCT_2 = 3'd2,
    OCT_3 = 3'd3,
    OCT_4 = 3'd4,
    OCT_5 = 3'd5,
    OCT_6 = 3'd6,
    OCT_7 = 3'd7
  } oct_t;

  // Per-beat flags carried alongside the datapath
  typedef struct packed {
    logic neg;        // phase was negative: negate sine at the end
    logic sine_dir;   // CORDIC result is the sine, root is the cosine
    logic other_neg;  // root output takes a minus sign
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

  // Fixed latency from accepted beat to strobe
  function automatic int occs_latency(input int stages, input int out_frac);
    return FRONT_REGS + stages + BACK_REGS + out_frac + 1;
  endfunction

  // Restoring long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Floor integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bits;
    n = val;
    r = '0;
    bits = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bits > n) bits = bits >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bits != 64'd0) begin
        if (n >= r + bits) begin
          n = n - (r + bits);
          r = (r >> 1) + bits;
        end else begin
          r = r >> 1;
        end
        bits = bits >> 2;
      end
    end
    return r;
  endfunction

  // atan(2^-i) in Q.40, series summed in Q.62 then rounded
  function automatic logic [63:0] atan_q40(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned e;
    sum = '0;
    if (i == 0) return (PI_Q60 + (64'd1 << 21)) >> 22;
    for (int k = 0; k < 32; k++) begin
      e = (2 * k + 1) * i;
      if (e <= 62) begin
        term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k[0]) sum = sum - term;
        else sum = sum + term;
      end
    end
    return (sum + (64'd1 << 21)) >> 22;
  endfunction

  // Inverse CORDIC gain in Q.40
  function automatic logic [63:0] gain_q40(input int unsigned stages);
    logic [63:0] k2;
    k2 = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (i < stages) k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    return isqrt64(k2) << (WORK_FRAC - 31);
  endfunction

endpackage

@@ design/occs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occs_front - phase reduction to a CORDIC angle
// Magnitude, octant pick and reflection, then scaling by 2*pi into Q.40.
// ----------------------------------------------------------------------------
module occs_front
  import occs_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [PHASE_W-1:0] phase,
  output logic                      out_valid,
  output logic signed [WORK_W-1:0]  z,
  output tag_t                      tag
);

  localparam int PFB      = PHASE_FRAC_BITS;
  localparam int RM_W     = PFB - 2;
  localparam int LO_W     = RM_W + TWO_PI_LO_W;
  localparam int HI_W     = RM_W + TWO_PI_HI_W;
  localparam int PROD_W   = RM_W + TWO_PI_W;
  localparam int THETA_SH = PFB - (WORK_FRAC - 32);
  localparam int THETA_W  = WORK_W - 1;

  localparam logic [PFB:0] QUARTER = (PFB + 1)'(1) << (PFB - 2);
  localparam logic [PFB:0] HALF    = QUARTER << 1;
  localparam logic [PFB:0] THREE_Q = QUARTER + HALF;
  localparam logic [PFB:0] TURN    = QUARTER << 2;

  // stage 1: input beat
  logic               v1;
  logic [PHASE_W-1:0] ph1;
  // stage 2: magnitude fraction
  logic               v2;
  logic               neg2;
  logic [PFB-1:0]     frac2;
  // stage 3: reflected magnitude
  logic               v3;
  logic               rneg3;
  tag_t               tag3;
  logic [RM_W-1:0]    rm3;
  // stage 4: partial products
  logic               v4;
  logic               rneg4;
  tag_t               tag4;
  logic [LO_W-1:0]    pp_lo4;
  logic [HI_W-1:0]    pp_hi4;
  // stage 5: angle magnitude
  logic               v5;
  logic               rneg5;
  tag_t               tag5;
  logic [THETA_W-1:0] theta5;

  logic [PHASE_W-1:0]       mag_next;
  oct_t                     oct;
  logic [PFB:0]             base;
  logic                     sub_from_base;
  logic                     rneg_next;
  tag_t                     tag_next;
  logic [PFB:0]             diff;
  logic [RM_W-1:0]          rm_next;
  logic [PROD_W-1:0]        prod;
  logic [THETA_W-1:0]       theta_next;
  logic signed [WORK_W-1:0] z_next;

  assign mag_next = ph1[PHASE_W-1] ? (~ph1) + PHASE_W'(1) : ph1;

  // Reflect into |r| <= 1/8 turn; an exact boundary falls in the upper octant
  always_comb begin
    oct = oct_t'(frac2[PFB-1 -: 3]);
    base = '0;
    sub_from_base = 1'b0;
    rneg_next = 1'b0;
    tag_next.neg = neg2;
    tag_next.sine_dir = 1'b1;
    tag_next.other_neg = 1'b0;
    unique case (oct)
      OCT_0: begin
        base = '0;       sub_from_base = 1'b0; rneg_next = 1'b0;
        tag_next.sine_dir = 1'b1; tag_next.other_neg = 1'b0;
      end
      OCT_1: begin
        base = QUARTER;  sub_from_base = 1'b1; rneg_next = 1'b0;
        tag_next.sine_dir = 1'b0; tag_next.other_neg = 1'b0;
      end
      OCT_2: begin
        base = QUARTER;  sub_from_base = 1'b0; rneg_next = 1'b1;
        tag_next.sine_dir = 1'b0; tag_next.other_neg = 1'b0;
      end
      OCT_3: begin
        base = HALF;     sub_from_base = 1'b1; rneg_next = 1'b0;
        tag_next.sine_dir = 1'b1; tag_next.other_neg = 1'b1;
      end
      OCT_4: begin
        base = HALF;     sub_from_base = 1'b0; rneg_next = 1'b1;
        tag_next.sine_dir = 1'b1; tag_next.other_neg = 1'b1;
      end
      OCT_5: begin
        base = THREE_Q;  sub_from_base = 1'b1; rneg_next = 1'b1;
        tag_next.sine_dir = 1'b0; tag_next.other_neg = 1'b1;
      end
      OCT_6: begin
        base = THREE_Q;  sub_from_base = 1'b0; rneg_next = 1'b0;
        tag_next.sine_dir = 1'b0; tag_next.other_neg = 1'b1;
      end
      OCT_7: begin
        base = TURN;     sub_from_base = 1'b1; rneg_next = 1'b1;
        tag_next.sine_dir = 1'b1; tag_next.other_neg = 1'b0;
      end
      default: begin
        base = '0;       sub_from_base = 1'b0; rneg_next = 1'b0;
      end
    endcase
  end

  assign diff    = sub_from_base ? base - {1'b0, frac2} : {1'b0, frac2} - base;
  assign rm_next = diff[RM_W-1:0];

  assign prod       = PROD_W'(pp_lo4) + (PROD_W'(pp_hi4) << TWO_PI_LO_W);
  assign theta_next = THETA_W'(prod >> THETA_SH);

  assign z_next = rneg5 ? -$signed({1'b0, theta5}) : $signed({1'b0, theta5});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    ph1    <= phase;
    neg2   <= ph1[PHASE_W-1];
    frac2  <= mag_next[PFB-1:0];
    rneg3  <= rneg_next;
    tag3   <= tag_next;
    rm3    <= rm_next;
    rneg4  <= rneg3;
    tag4   <= tag3;
    pp_lo4 <= LO_W'(rm3) * LO_W'(TWO_PI_LO);
    pp_hi4 <= HI_W'(rm3) * HI_W'(TWO_PI_HI);
    rneg5  <= rneg4;
    tag5   <= tag4;
    theta5 <= theta_next;
    z      <= z_next;
    tag    <= tag5;
  end

endmodule

@@ design/occs_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occs_cordic_cell - one rotation-mode CORDIC micro-rotation
// Shift by the cell index, add/subtract, register; atan constant per cell.
// ----------------------------------------------------------------------------
module occs_cordic_cell
  import occs_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [WORK_W-1:0] in_x,
  input  logic signed [WORK_W-1:0] in_y,
  input  logic signed [WORK_W-1:0] in_z,
  input  tag_t                     in_tag,
  output logic                     out_valid,
  output logic signed [WORK_W-1:0] out_x,
  output logic signed [WORK_W-1:0] out_y,
  output logic signed [WORK_W-1:0] out_z,
  output tag_t                     out_tag
);

  localparam logic signed [WORK_W-1:0] ATAN = WORK_W'(atan_q40(STAGE));

  logic signed [WORK_W-1:0] dx;
  logic signed [WORK_W-1:0] dy;
  logic                     rot_pos;
  logic signed [WORK_W-1:0] x_next;
  logic signed [WORK_W-1:0] y_next;
  logic signed [WORK_W-1:0] z_next;

  // flooring shifts
  assign dx      = in_y >>> STAGE;
  assign dy      = in_x >>> STAGE;
  assign rot_pos = ~in_z[WORK_W-1];

  assign x_next = rot_pos ? in_x - dx   : in_x + dx;
  assign y_next = rot_pos ? in_y + dy   : in_y - dy;
  assign z_next = rot_pos ? in_z - ATAN : in_z + ATAN;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_x   <= x_next;
    out_y   <= y_next;
    out_z   <= z_next;
    out_tag <= in_tag;
  end

endmodule

@@ design/occs_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occs_sqrt_cell - one digit of a restoring integer square root
// Brings down two radicand bits, trial-subtracts, shifts in one root bit.
// ----------------------------------------------------------------------------
module occs_sqrt_cell
  import occs_pkg::*;
#(
  parameter int N      = OUT_FRAC_BITS_DEF + 1,
  parameter int SIDE_W = TAG_W + OUT_FRAC_BITS_DEF + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2*N-1:0]    in_rad,
  input  logic [N+1:0]      in_rem,
  input  logic [N-1:0]      in_q,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [2*N-1:0]    out_rad,
  output logic [N+1:0]      out_rem,
  output logic [N-1:0]      out_q,
  output logic [SIDE_W-1:0] out_side
);

  logic [N+1:0] rem_sh;
  logic [N+1:0] trial;
  logic         take;
  logic [N+1:0] rem_next;

  // remainder stays below 2^N going in, so its top two bits are zero
  assign rem_sh   = {in_rem[N-1:0], in_rad[2*N-1 -: 2]};
  assign trial    = {in_q, 2'b01};
  assign take     = rem_sh >= trial;
  assign rem_next = take ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rad  <= {in_rad[2*N-3:0], 2'b00};
    out_rem  <= rem_next;
    out_q    <= {in_q[N-2:0], take};
    out_side <= in_side;
  end

endmodule

@@ design/octant_cos_sin_of_turns_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octant_cos_sin_of_turns_unit - cos/sin of a phase in turns
// Octant reduction, CORDIC sine of a small angle, digit-serial square root
// for the partner output, all as fixed-latency pipelines.
// ----------------------------------------------------------------------------
// A phase beat is taken on any clock edge where start is high and busy is
// low; busy is high only while rst is held, so a new phase can go in on every
// clock. The matching cosine and sine appear on their ports for exactly one
// cycle with done high, in order, one result per beat. The pipeline depth
// comes from the front-end registers, the row of CORDIC cells (one per
// micro-rotation), the row of square-root cells (one per root bit) and the
// back-end registers; throughput is one beat per clock outside reset. The
// receiver cannot stall: done is a strobe, and a result that is not
// captured in its cycle is gone. Outputs are Q1.OUT_FRAC_BITS, clamped to
// plus or minus one and truncated to the 18-bit ports.
// ----------------------------------------------------------------------------
module octant_cos_sin_of_turns_unit
  import occs_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [PHASE_W-1:0] phase,
  output logic                      busy,
  output logic                      done,
  output logic signed [OUT_W-1:0]   cosine,
  output logic signed [OUT_W-1:0]   sine
);

  localparam int S      = CORDIC_STAGES;
  localparam int OFB    = OUT_FRAC_BITS;
  localparam int N      = OFB + 1;          // root bits, root <= 2^OFB
  localparam int D_W    = OFB + 2;          // signed direct output
  localparam int RAD_W  = 2 * N;
  localparam int REM_W  = N + 2;
  localparam int SIDE_W = TAG_W + D_W;
  localparam int RND_SH = WORK_FRAC - OFB;
  localparam int EXT_W  = (D_W + 1 > OUT_W) ? D_W + 1 : OUT_W;

  localparam logic signed [WORK_W-1:0] GAIN       = WORK_W'(gain_q40(S));
  localparam logic signed [WORK_W-1:0] ROUND_HALF = WORK_W'(64'd1 << (RND_SH - 1));
  localparam logic signed [WORK_W-1:0] ONE_W      = WORK_W'(64'd1 << OFB);
  localparam logic signed [D_W-1:0]    ONE_D      = D_W'(64'd1 << OFB);

  logic accept;

  // Only reset holds off a beat; the pipeline never back-pressures.
  assign busy   = rst;
  assign accept = start & ~busy;

  // --------------------------------------------------------------------------
  // Front end: |phase|, octant, reflected angle, scale to radians Q.40
  // --------------------------------------------------------------------------
  logic                     fv;
  logic signed [WORK_W-1:0] fz;
  tag_t                     ftag;

  occs_front #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .phase    (phase),
    .out_valid(fv),
    .z        (fz),
    .tag      (ftag)
  );

  // --------------------------------------------------------------------------
  // CORDIC row: x starts at the inverse gain, so y ends as sin(z)
  // --------------------------------------------------------------------------
  logic                     cv [0:S];
  logic signed [WORK_W-1:0] cx [0:S];
  logic signed [WORK_W-1:0] cy [0:S];
  logic signed [WORK_W-1:0] cz [0:S];
  tag_t                     ct [0:S];

  assign cv[0] = fv;
  assign cx[0] = GAIN;
  assign cy[0] = '0;
  assign cz[0] = fz;
  assign ct[0] = ftag;

  for (genvar i = 0; i < S; i++) begin : g_cordic
    occs_cordic_cell #(
      .STAGE(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[i]),
      .in_x     (cx[i]),
      .in_y     (cy[i]),
      .in_z     (cz[i]),
      .in_tag   (ct[i]),
      .out_valid(cv[i+1]),
      .out_x    (cx[i+1]),
      .out_y    (cy[i+1]),
      .out_z    (cz[i+1]),
      .out_tag  (ct[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Direct output: round half up to OUT_FRAC_BITS, clamp to +/-1
  // --------------------------------------------------------------------------
  logic signed [WORK_W-1:0] yr;
  logic signed [D_W-1:0]    d_next;

  assign yr = (cy[S] + ROUND_HALF) >>> RND_SH;

  always_comb begin
    priority if (yr > ONE_W) begin
      d_next = ONE_D;
    end else if (yr < -ONE_W) begin
      d_next = -ONE_D;
    end else begin
      d_next = D_W'(yr);
    end
  end

  logic                  b1_valid;
  logic signed [D_W-1:0] b1_d;
  tag_t                  b1_tag;

  // (1 + d) and (1 - d), both in [0, 2]
  logic                  b2_valid;
  logic [D_W-1:0]        b2_a;
  logic [D_W-1:0]        b2_b;
  logic signed [D_W-1:0] b2_d;
  tag_t                  b2_tag;

  // radicand 1 - d^2, formed without a signed square
  logic                  b3_valid;
  logic [RAD_W-1:0]      b3_rad;
  logic signed [D_W-1:0] b3_d;
  tag_t                  b3_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
    end else begin
      b1_valid <= cv[S];
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    b1_d   <= d_next;
    b1_tag <= ct[S];
    b2_a   <= ONE_D + b1_d;
    b2_b   <= ONE_D - b1_d;
    b2_d   <= b1_d;
    b2_tag <= b1_tag;
    b3_rad <= RAD_W'(b2_a) * RAD_W'(b2_b);
    b3_d   <= b2_d;
    b3_tag <= b2_tag;
  end

  // --------------------------------------------------------------------------
  // Square-root row: one root bit per cell, MSB first; d and tag ride along
  // --------------------------------------------------------------------------
  logic              sv    [0:N];
  logic [RAD_W-1:0]  srad  [0:N];
  logic [REM_W-1:0]  srem  [0:N];
  logic [N-1:0]      sq    [0:N];
  logic [SIDE_W-1:0] sside [0:N];

  assign sv[0]    = b3_valid;
  assign srad[0]  = b3_rad;
  assign srem[0]  = '0;
  assign sq[0]    = '0;
  assign sside[0] = {b3_tag, b3_d};

  for (genvar j = 0; j < N; j++) begin : g_sqrt
    occs_sqrt_cell #(
      .N     (N),
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sv[j]),
      .in_rad   (srad[j]),
      .in_rem   (srem[j]),
      .in_q     (sq[j]),
      .in_side  (sside[j]),
      .out_valid(sv[j+1]),
      .out_rad  (srad[j+1]),
      .out_rem  (srem[j+1]),
      .out_q    (sq[j+1]),
      .out_side (sside[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // Round the root to nearest, sign it, steer onto cosine/sine
  // --------------------------------------------------------------------------
  logic [N-1:0] root_next;

  // remainder above the floor root means the true root is past q + 1/2
  assign root_next = (srem[N] > REM_W'(sq[N])) ? sq[N] + N'(1) : sq[N];

  logic                  b4_valid;
  logic [N-1:0]          b4_root;
  logic signed [D_W-1:0] b4_d;
  tag_t                  b4_tag;

  logic                  b5_valid;
  logic signed [D_W-1:0] b5_other;
  logic signed [D_W-1:0] b5_d;
  tag_t                  b5_tag;

  logic signed [D_W-1:0] other_next;

  assign other_next = b4_tag.other_neg ? -$signed({1'b0, b4_root}) : $signed({1'b0, b4_root});

  logic signed [EXT_W-1:0] c_ext;
  logic signed [EXT_W-1:0] s_sel;
  logic signed [EXT_W-1:0] s_ext;

  assign c_ext = b5_tag.sine_dir ? EXT_W'(b5_other) : EXT_W'(b5_d);
  assign s_sel = b5_tag.sine_dir ? EXT_W'(b5_d) : EXT_W'(b5_other);
  assign s_ext = b5_tag.neg ? -s_sel : s_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      b4_valid <= 1'b0;
      b5_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      b4_valid <= sv[N];
      b5_valid <= b4_valid;
      done     <= b5_valid;
    end
  end

  always_ff @(posedge clk) begin
    b4_root  <= root_next;
    b4_d     <= sside[N][D_W-1:0];
    b4_tag   <= tag_t'(sside[N][SIDE_W-1 -: TAG_W]);
    b5_other <= other_next;
    b5_d     <= b4_d;
    b5_tag   <= b4_tag;
    cosine   <= c_ext[OUT_W-1:0];
    sine     <= s_ext[OUT_W-1:0];
  end

endmodule

@@ design/occs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occs_checker - port-level checks for the octant cosine/sine unit
// Fixed latency in both directions, quiet after reset, unit-circle sanity.
// ----------------------------------------------------------------------------
module occs_checker
  import occs_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic signed [OUT_W-1:0] cosine,
  input logic signed [OUT_W-1:0] sine
);

  localparam int LAT = occs_latency(CORDIC_STAGES, OUT_FRAC_BITS);

  // every taken beat is answered by done at the occs_latency offset
  a_beat_returns: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("taken beat produced no result at the expected cycle");

  // no result without a matching beat taken at the occs_latency offset
  a_no_stray: assert property (@(posedge clk)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe with no matching beat");

  a_quiet_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe straight after reset");

  // only meaningful while the full Q1 range fits the ports
  if (OUT_FRAC_BITS <= 16) begin : g_range
    localparam int PW_W = 2 * OUT_W + 2;
    localparam logic signed [OUT_W-1:0] ONE_S  = OUT_W'(64'd1 << OUT_FRAC_BITS);
    localparam logic signed [PW_W-1:0]  ONE_SQ = PW_W'(64'd1 << (2 * OUT_FRAC_BITS));
    localparam logic signed [PW_W-1:0]  SLACK  = PW_W'((64'd1 << OUT_FRAC_BITS) + 64'd1);

    logic signed [PW_W-1:0] pw;

    assign pw = PW_W'(cosine) * PW_W'(cosine) + PW_W'(sine) * PW_W'(sine);

    a_in_range: assert property (@(posedge clk) disable iff (rst)
      done |-> (cosine <= ONE_S && cosine >= -ONE_S && sine <= ONE_S && sine >= -ONE_S))
      else $error("output outside plus or minus one");

    // rounded root keeps cos^2 + sin^2 within one LSB-scaled root of 1
    a_unit_circle: assert property (@(posedge clk) disable iff (rst)
      done |-> (pw <= ONE_SQ + SLACK && pw >= ONE_SQ - SLACK))
      else $error("cosine and sine off the unit circle");
  end

endmodule

bind octant_cos_sin_of_turns_unit occs_checker #(
  .OUT_FRAC_BITS(OUT_FRAC_BITS),
  .CORDIC_STAGES(CORDIC_STAGES)
) u_occs_checker (.*);
